FILE: hdl/cmg_pkg.sv
// Shared types, widths and constants of the cylinder mesh generator.
package cmg_pkg;

    localparam int RADIUS_W  = 16;
    localparam int HEIGHT_W  = 16;
    localparam int COUNT_W   = 11;
    localparam int INDEX_W   = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int MAX_SEGMENTS_DEF = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENTS = 2'd2;

    // Divider: 43-bit dividend, 18-bit divisor, 33 quotient bits, one bit per stage.
    localparam int DIV_N_W   = 43;
    localparam int DIV_D_W   = 18;
    localparam int DIV_Q_W   = 33;
    localparam int DIV_LANES = 3;

    localparam int PHASE_W       = 32;
    localparam int CORDIC_STEPS  = 16;
    localparam int CORDIC_W      = 34;
    localparam int ZW            = 32;
    localparam int TRIG_W        = 32;
    localparam int CORDIC_LANES  = 2;
    localparam int TEX_W         = 17;
    localparam int TAG_W         = 2 * TEX_W;
    localparam int POS_W         = 17;
    localparam int NORM_W        = 16;
    localparam int PROD_W        = RADIUS_W + 1 + TRIG_W;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [TEX_W-1:0]         TEX_ONE  = 17'd65536;
    localparam logic [TEX_W-1:0]         TEX_HALF = 17'd32768;
    localparam logic signed [NORM_W-1:0] NORM_ONE = 16'sd16384;

    typedef enum logic [1:0] {SRC_A1, SRC_A2, SRC_CENTER} vsrc_t;
    typedef enum logic [1:0] {NRM_SIDE, NRM_UP, NRM_DOWN} nrm_t;

    typedef struct packed {
        vsrc_t src;
        logic  top;
        nrm_t  nrm;
    } vsel_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  x1;
        logic signed [POS_W-1:0]  z1;
        logic signed [POS_W-1:0]  x2;
        logic signed [POS_W-1:0]  z2;
        logic signed [NORM_W-1:0] nx1;
        logic signed [NORM_W-1:0] nz1;
        logic signed [NORM_W-1:0] nx2;
        logic signed [NORM_W-1:0] nz2;
        logic [TEX_W-1:0]         u1;
        logic [TEX_W-1:0]         u2;
        logic [TEX_W-1:0]         vt;
        logic [TEX_W-1:0]         vb;
    } seg_t;

    // atan(2^-i) in turns scaled by 2^32
    function automatic logic signed [ZW-1:0] atan_turn(input int idx);
        logic signed [ZW-1:0] a;
        case (idx)
            0:  a = 32'sh20000000;
            1:  a = 32'sh12E4051D;
            2:  a = 32'sh09FB385B;
            3:  a = 32'sh051111D4;
            4:  a = 32'sh028B0D43;
            5:  a = 32'sh0145D7E1;
            6:  a = 32'sh00A2F61E;
            7:  a = 32'sh00517C55;
            8:  a = 32'sh0028BE53;
            9:  a = 32'sh00145F2E;
            10: a = 32'sh000A2F98;
            11: a = 32'sh000517CC;
            12: a = 32'sh00028BE6;
            13: a = 32'sh000145F3;
            14: a = 32'sh0000A2F9;
            15: a = 32'sh0000517C;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Which corner data a vertex of the four triangles takes.
    function automatic vsel_t vertex_sel(input logic [1:0] face, input logic [1:0] corner);
        vsel_t s;
        s = '{src: SRC_A1, top: 1'b1, nrm: NRM_SIDE};
        case ({face, corner})
            4'b00_00: s = '{src: SRC_A1,     top: 1'b1, nrm: NRM_SIDE};
            4'b00_01: s = '{src: SRC_A2,     top: 1'b1, nrm: NRM_SIDE};
            4'b00_10: s = '{src: SRC_A1,     top: 1'b0, nrm: NRM_SIDE};
            4'b01_00: s = '{src: SRC_A2,     top: 1'b1, nrm: NRM_SIDE};
            4'b01_01: s = '{src: SRC_A2,     top: 1'b0, nrm: NRM_SIDE};
            4'b01_10: s = '{src: SRC_A1,     top: 1'b0, nrm: NRM_SIDE};
            4'b10_00: s = '{src: SRC_A1,     top: 1'b1, nrm: NRM_UP};
            4'b10_01: s = '{src: SRC_CENTER, top: 1'b1, nrm: NRM_UP};
            4'b10_10: s = '{src: SRC_A2,     top: 1'b1, nrm: NRM_UP};
            4'b11_00: s = '{src: SRC_A2,     top: 1'b0, nrm: NRM_DOWN};
            4'b11_01: s = '{src: SRC_CENTER, top: 1'b0, nrm: NRM_DOWN};
            4'b11_10: s = '{src: SRC_A1,     top: 1'b0, nrm: NRM_DOWN};
            default:  s = '{src: SRC_A1,     top: 1'b1, nrm: NRM_SIDE};
        endcase
        return s;
    endfunction

endpackage

FILE: hdl/cmg_div.sv
// Pipelined restoring divider, several lanes in lockstep, one quotient bit per stage.
module cmg_div import cmg_pkg::*; (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [DIV_LANES-1:0][DIV_N_W-1:0]   num,
    input  logic [DIV_LANES-1:0][DIV_D_W-1:0]   den,
    output logic                                out_valid,
    output logic [DIV_LANES-1:0][DIV_Q_W-1:0]   quot,
    output logic [DIV_LANES-1:0][DIV_D_W-1:0]   rem
);

    logic [DIV_Q_W-1:0] vld_reg;
    logic [DIV_D_W-1:0] rem_reg [DIV_LANES][DIV_Q_W];
    logic [DIV_Q_W-1:0] nq_reg  [DIV_LANES][DIV_Q_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DIV_Q_W-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[DIV_Q_W-1];

    for (genvar l = 0; l < DIV_LANES; l++) begin : g_lane
        for (genvar s = 0; s < DIV_Q_W; s++) begin : g_stage
            logic [DIV_D_W-1:0] rem_in;
            logic [DIV_Q_W-1:0] nq_in;
            logic [DIV_D_W:0]   sh;
            logic               ge;

            if (s == 0) begin : g_first
                assign rem_in = DIV_D_W'(num[l][DIV_N_W-1:DIV_Q_W]);
                assign nq_in  = num[l][DIV_Q_W-1:0];
            end else begin : g_next
                assign rem_in = rem_reg[l][s-1];
                assign nq_in  = nq_reg[l][s-1];
            end

            assign sh = {rem_in, nq_in[DIV_Q_W-1]};
            assign ge = sh >= {1'b0, den[l]};

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[l][s] <= ge ? DIV_D_W'(sh - {1'b0, den[l]}) : sh[DIV_D_W-1:0];
                    nq_reg[l][s]  <= {nq_in[DIV_Q_W-2:0], ge};
                end
            end
        end

        assign quot[l] = nq_reg[l][DIV_Q_W-1];
        assign rem[l]  = rem_reg[l][DIV_Q_W-1];
    end

endmodule

FILE: hdl/cmg_cordic.sv
// Pipelined rotation CORDIC, two angle lanes, quadrant fold on the output stage.
module cmg_cordic import cmg_pkg::*; (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic [CORDIC_LANES-1:0][PHASE_W-1:0]  phase,
    input  logic [CORDIC_LANES-1:0][TAG_W-1:0]    tag_in,
    output logic                                  out_valid,
    output logic [CORDIC_LANES-1:0][TRIG_W-1:0]   cos_out,
    output logic [CORDIC_LANES-1:0][TRIG_W-1:0]   sin_out,
    output logic [CORDIC_LANES-1:0][TAG_W-1:0]    tag_out
);

    logic [CORDIC_STEPS-1:0] vld_reg;
    logic                    vld_o_reg;

    logic signed [CORDIC_W-1:0] x_reg    [CORDIC_LANES][CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] y_reg    [CORDIC_LANES][CORDIC_STEPS];
    logic signed [ZW-1:0]       z_reg    [CORDIC_LANES][CORDIC_STEPS];
    logic [1:0]                 quad_reg [CORDIC_LANES][CORDIC_STEPS];
    logic [TAG_W-1:0]           tag_reg  [CORDIC_LANES][CORDIC_STEPS];

    logic [CORDIC_LANES-1:0][TRIG_W-1:0] cos_reg;
    logic [CORDIC_LANES-1:0][TRIG_W-1:0] sin_reg;
    logic [CORDIC_LANES-1:0][TAG_W-1:0]  tag_o_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            vld_o_reg <= 1'b0;
        end else if (en) begin
            vld_reg   <= {vld_reg[CORDIC_STEPS-2:0], in_valid};
            vld_o_reg <= vld_reg[CORDIC_STEPS-1];
        end
    end

    assign out_valid = vld_o_reg;
    assign cos_out   = cos_reg;
    assign sin_out   = sin_reg;
    assign tag_out   = tag_o_reg;

    for (genvar l = 0; l < CORDIC_LANES; l++) begin : g_lane
        for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
            logic signed [CORDIC_W-1:0] x_in;
            logic signed [CORDIC_W-1:0] y_in;
            logic signed [ZW-1:0]       z_in;
            logic [1:0]                 quad_in;
            logic [TAG_W-1:0]           t_in;
            logic signed [CORDIC_W-1:0] dx;
            logic signed [CORDIC_W-1:0] dy;

            if (s == 0) begin : g_first
                assign x_in    = CORDIC_GAIN;
                assign y_in    = '0;
                assign z_in    = $signed({2'b00, phase[l][PHASE_W-3:0]});
                assign quad_in = phase[l][PHASE_W-1:PHASE_W-2];
                assign t_in    = tag_in[l];
            end else begin : g_next
                assign x_in    = x_reg[l][s-1];
                assign y_in    = y_reg[l][s-1];
                assign z_in    = z_reg[l][s-1];
                assign quad_in = quad_reg[l][s-1];
                assign t_in    = tag_reg[l][s-1];
            end

            assign dx = y_in >>> s;
            assign dy = x_in >>> s;

            always_ff @(posedge aclk) begin
                if (en) begin
                    if (!z_in[ZW-1]) begin
                        x_reg[l][s] <= x_in - dx;
                        y_reg[l][s] <= y_in + dy;
                        z_reg[l][s] <= z_in - atan_turn(s);
                    end else begin
                        x_reg[l][s] <= x_in + dx;
                        y_reg[l][s] <= y_in - dy;
                        z_reg[l][s] <= z_in + atan_turn(s);
                    end
                    quad_reg[l][s] <= quad_in;
                    tag_reg[l][s]  <= t_in;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                tag_o_reg[l] <= tag_reg[l][CORDIC_STEPS-1];
                case (quad_reg[l][CORDIC_STEPS-1])
                    2'd0: begin
                        cos_reg[l] <= TRIG_W'(x_reg[l][CORDIC_STEPS-1]);
                        sin_reg[l] <= TRIG_W'(y_reg[l][CORDIC_STEPS-1]);
                    end
                    2'd1: begin
                        cos_reg[l] <= TRIG_W'(-y_reg[l][CORDIC_STEPS-1]);
                        sin_reg[l] <= TRIG_W'(x_reg[l][CORDIC_STEPS-1]);
                    end
                    2'd2: begin
                        cos_reg[l] <= TRIG_W'(-x_reg[l][CORDIC_STEPS-1]);
                        sin_reg[l] <= TRIG_W'(-y_reg[l][CORDIC_STEPS-1]);
                    end
                    default: begin
                        cos_reg[l] <= TRIG_W'(y_reg[l][CORDIC_STEPS-1]);
                        sin_reg[l] <= TRIG_W'(-x_reg[l][CORDIC_STEPS-1]);
                    end
                endcase
            end
        end
    end

endmodule

FILE: hdl/cmg_emit.sv
// Output sequencer: holds one segment and steps through its twelve vertices.
module cmg_emit import cmg_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    input  seg_t                     in_seg,
    input  logic [HEIGHT_W-2:0]      half,
    output logic                     take,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_face_number,
    output logic [1:0]               m_corner,
    output logic signed [POS_W-1:0]  m_pos_x,
    output logic signed [POS_W-1:0]  m_pos_y,
    output logic signed [POS_W-1:0]  m_pos_z,
    output logic signed [NORM_W-1:0] m_norm_x,
    output logic signed [NORM_W-1:0] m_norm_y,
    output logic signed [NORM_W-1:0] m_norm_z,
    output logic [TEX_W-1:0]         m_tex_u,
    output logic [TEX_W-1:0]         m_tex_v,
    output logic                     m_last_vertex
);

    logic       hold_vld_reg;
    seg_t       seg_reg;
    logic [1:0] face_reg;
    logic [1:0] corner_reg;
    logic       last;
    vsel_t      sel;
    logic signed [POS_W-1:0] half_s;

    assign last = (face_reg == 2'd3) && (corner_reg == 2'd2);
    assign take = !hold_vld_reg || (m_ready && last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_vld_reg <= 1'b0;
            face_reg     <= '0;
            corner_reg   <= '0;
        end else if (take) begin
            hold_vld_reg <= in_valid;
            face_reg     <= '0;
            corner_reg   <= '0;
        end else if (m_ready) begin
            if (corner_reg == 2'd2) begin
                corner_reg <= '0;
                face_reg   <= face_reg + 2'd1;
            end else begin
                corner_reg <= corner_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            seg_reg <= in_seg;
        end
    end

    assign half_s = $signed({2'b00, half});

    always_comb begin
        sel           = vertex_sel(face_reg, corner_reg);
        m_valid       = hold_vld_reg;
        m_face_number = face_reg;
        m_corner      = corner_reg;
        m_last_vertex = last;
        m_pos_y       = sel.top ? half_s : -half_s;
        case (sel.src)
            SRC_A1: begin
                m_pos_x  = seg_reg.x1;
                m_pos_z  = seg_reg.z1;
                m_norm_x = seg_reg.nx1;
                m_norm_z = seg_reg.nz1;
                m_tex_u  = seg_reg.u1;
                m_tex_v  = sel.top ? seg_reg.vt : seg_reg.vb;
            end
            SRC_A2: begin
                m_pos_x  = seg_reg.x2;
                m_pos_z  = seg_reg.z2;
                m_norm_x = seg_reg.nx2;
                m_norm_z = seg_reg.nz2;
                m_tex_u  = seg_reg.u2;
                m_tex_v  = sel.top ? seg_reg.vt : seg_reg.vb;
            end
            default: begin
                m_pos_x  = '0;
                m_pos_z  = '0;
                m_norm_x = '0;
                m_norm_z = '0;
                m_tex_u  = TEX_HALF;
                m_tex_v  = sel.top ? '0 : TEX_ONE;
            end
        endcase
        case (sel.nrm)
            NRM_UP: begin
                m_norm_x = '0;
                m_norm_y = NORM_ONE;
                m_norm_z = '0;
            end
            NRM_DOWN: begin
                m_norm_x = '0;
                m_norm_y = -NORM_ONE;
                m_norm_z = '0;
            end
            default: begin
                m_norm_y = '0;
            end
        endcase
    end

endmodule

FILE: hdl/cylinder_mesh_generator_unit.sv
// Cylinder mesh generator top level: config registers, pipeline stages and sequencer.
//
//  channel   dir  handshake            payload
//  s_        in   s_valid/s_ready      s_segment_index
//  m_        out  m_valid/m_ready      face, corner, position, normal, texture, last
//  cfg_      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One segment index yields twelve vertices, one per cycle while m_ready is high, so a new
// index is taken only once the last vertex of the held segment is accepted; the output sequencer sets that pace.
// From acceptance to the first vertex the path runs through the index stage, 33 divider
// stages, phase stage, 17 CORDIC stages, multiply stage and rounding stage.
// aresetn is synchronous; it clears valid bits and loads the register defaults.
// A stall on m_ready freezes every stage at once, so nothing is lost or repeated.
module cylinder_mesh_generator_unit import cmg_pkg::*; #(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DAT_W-1:0]     cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [INDEX_W-1:0]       s_segment_index,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_face_number,
    output logic [1:0]               m_corner,
    output logic signed [POS_W-1:0]  m_pos_x,
    output logic signed [POS_W-1:0]  m_pos_y,
    output logic signed [POS_W-1:0]  m_pos_z,
    output logic signed [NORM_W-1:0] m_norm_x,
    output logic signed [NORM_W-1:0] m_norm_y,
    output logic signed [NORM_W-1:0] m_norm_z,
    output logic [TEX_W-1:0]         m_tex_u,
    output logic [TEX_W-1:0]         m_tex_v,
    output logic                     m_last_vertex
);

    logic [RADIUS_W-1:0] radius_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [COUNT_W-1:0]  seg_cnt_reg;

    logic                en;
    logic [COUNT_W-1:0]  count_nz;
    logic [COUNT_W-1:0]  count_eff;
    logic [COUNT_W-1:0]  half_cnt;
    logic [DIV_D_W-1:0]  den_v;
    logic [DIV_D_W-1:0]  half_den;
    logic [INDEX_W-1:0]  idx_clamped;

    // index stage
    logic               a_vld_reg;
    logic [INDEX_W-1:0] a_idx_reg;

    // divider
    logic                              div_vld;
    logic [DIV_LANES-1:0][DIV_N_W-1:0] div_num;
    logic [DIV_LANES-1:0][DIV_D_W-1:0] div_den;
    logic [DIV_LANES-1:0][DIV_Q_W-1:0] div_q;
    logic [DIV_LANES-1:0][DIV_D_W-1:0] div_r;

    // phase stage
    logic                                  b_vld_reg;
    logic [CORDIC_LANES-1:0][PHASE_W-1:0]  b_phase_reg;
    logic [CORDIC_LANES-1:0][TAG_W-1:0]    b_tag_reg;
    logic [CORDIC_LANES-1:0][PHASE_W-1:0]  phase_next;
    logic [CORDIC_LANES-1:0][TEX_W-1:0]    u_next;
    logic [TEX_W-1:0]                      vt_next;
    logic [TEX_W-1:0]                      vb_next;

    // CORDIC
    logic                                 cor_vld;
    logic [CORDIC_LANES-1:0][TRIG_W-1:0]  cor_cos;
    logic [CORDIC_LANES-1:0][TRIG_W-1:0]  cor_sin;
    logic [CORDIC_LANES-1:0][TAG_W-1:0]   cor_tag;

    // multiply stage: products ordered x1, z1, x2, z2
    logic                       d_vld_reg;
    logic signed [PROD_W-1:0]   d_prod_reg [4];
    logic signed [NORM_W-1:0]   d_norm_reg [4];
    logic [CORDIC_LANES-1:0][TAG_W-1:0] d_tag_reg;

    // rounding stage
    logic e_vld_reg;
    seg_t e_seg_reg;

    function automatic logic signed [NORM_W-1:0] to_norm(input logic [TRIG_W-1:0] q);
        logic signed [TRIG_W:0]    t;
        logic signed [TRIG_W-16:0] s;
        t = $signed({q[TRIG_W-1], q}) + $signed((TRIG_W+1)'(32768));
        s = t[TRIG_W:16];
        if (s > $signed((TRIG_W-15)'(16384))) begin
            s = $signed((TRIG_W-15)'(16384));
        end else if (s < -$signed((TRIG_W-15)'(16384))) begin
            s = -$signed((TRIG_W-15)'(16384));
        end
        return NORM_W'(s);
    endfunction

    function automatic logic signed [POS_W-1:0] to_pos(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0]    t;
        logic signed [PROD_W-31:0]   s;
        t = p + $signed(PROD_W'(64'd536870912));
        s = t[PROD_W-1:30];
        if (s > $signed((PROD_W-30)'(65535))) begin
            s = $signed((PROD_W-30)'(65535));
        end else if (s < -$signed((PROD_W-30)'(65535))) begin
            s = -$signed((PROD_W-30)'(65535));
        end
        return POS_W'(s);
    endfunction

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg  <= RADIUS_W'(256);
            height_reg  <= HEIGHT_W'(512);
            seg_cnt_reg <= COUNT_W'(16);
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_RADIUS:   radius_reg  <= cfg_data[RADIUS_W-1:0];
                CFG_HEIGHT:   height_reg  <= cfg_data[HEIGHT_W-1:0];
                CFG_SEGMENTS: seg_cnt_reg <= cfg_data[COUNT_W-1:0];
                default:      ;
            endcase
        end
    end

    // effective count, divisors and index clamp
    always_comb begin
        count_nz  = (seg_cnt_reg == '0) ? COUNT_W'(1) : seg_cnt_reg;
        count_eff = (int'(count_nz) > MAX_SEGMENTS) ? COUNT_W'(MAX_SEGMENTS) : count_nz;
        half_cnt  = count_eff >> 1;
        den_v     = {1'b0, radius_reg, 1'b0} + {2'b00, height_reg};
        half_den  = den_v >> 1;
        if ({1'b0, s_segment_index} >= count_eff) begin
            idx_clamped = INDEX_W'(count_eff - COUNT_W'(1));
        end else begin
            idx_clamped = s_segment_index;
        end
    end

    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_idx_reg <= idx_clamped;
        end
    end

    // lanes: angle i, angle i+1, texture v bound
    assign div_num[0] = {1'b0, a_idx_reg, 32'd0};
    assign div_num[1] = {COUNT_W'({1'b0, a_idx_reg}) + COUNT_W'(1), 32'd0};
    assign div_num[2] = {11'd0, radius_reg, 16'd0};
    assign div_den[0] = DIV_D_W'(count_eff);
    assign div_den[1] = DIV_D_W'(count_eff);
    assign div_den[2] = den_v;

    cmg_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (a_vld_reg),
        .num       (div_num),
        .den       (div_den),
        .out_valid (div_vld),
        .quot      (div_q),
        .rem       (div_r)
    );

    // round phase and u from one quotient; derive both v bounds from one division
    always_comb begin
        logic [COUNT_W-1:0]   r_lo;
        logic [26:0]          p;
        logic [COUNT_W-1:0]   r16;
        logic                 rnd;
        logic [TEX_W-1:0]     q3;
        for (int l = 0; l < CORDIC_LANES; l++) begin
            r_lo = div_r[l][COUNT_W-1:0];
            rnd  = ({1'b0, r_lo} + {1'b0, half_cnt}) >= {1'b0, count_eff};
            phase_next[l] = PHASE_W'(div_q[l] + DIV_Q_W'(rnd));
            p    = 27'(div_q[l][15:0]) * 27'(count_eff) + 27'(r_lo);
            r16  = p[26:16];
            rnd  = ({1'b0, r16} + {1'b0, half_cnt}) >= {1'b0, count_eff};
            u_next[l] = div_q[l][DIV_Q_W-1:16] + TEX_W'(rnd);
        end
        q3 = div_q[2][TEX_W-1:0];
        if (den_v == '0) begin
            vt_next = '0;
            vb_next = '0;
        end else begin
            rnd     = ({1'b0, div_r[2]} + {1'b0, half_den}) >= {1'b0, den_v};
            vt_next = q3 + TEX_W'(rnd);
            if (div_r[2] == '0) begin
                vb_next = TEX_ONE - q3;
            end else begin
                vb_next = TEX_W'(65535) - q3 + TEX_W'(half_den >= div_r[2]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (en) begin
            b_vld_reg <= div_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_phase_reg  <= phase_next;
            b_tag_reg[0] <= {u_next[0], vt_next};
            b_tag_reg[1] <= {u_next[1], vb_next};
        end
    end

    cmg_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (b_vld_reg),
        .phase     (b_phase_reg),
        .tag_in    (b_tag_reg),
        .out_valid (cor_vld),
        .cos_out   (cor_cos),
        .sin_out   (cor_sin),
        .tag_out   (cor_tag)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
        end else if (en) begin
            d_vld_reg <= cor_vld;
            e_vld_reg <= d_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < CORDIC_LANES; l++) begin
                d_prod_reg[2*l]     <= $signed({1'b0, radius_reg}) * $signed(cor_cos[l]);
                d_prod_reg[2*l + 1] <= $signed({1'b0, radius_reg}) * $signed(cor_sin[l]);
                d_norm_reg[2*l]     <= to_norm(cor_cos[l]);
                d_norm_reg[2*l + 1] <= to_norm(cor_sin[l]);
            end
            d_tag_reg <= cor_tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_seg_reg.x1  <= to_pos(d_prod_reg[0]);
            e_seg_reg.z1  <= to_pos(d_prod_reg[1]);
            e_seg_reg.x2  <= to_pos(d_prod_reg[2]);
            e_seg_reg.z2  <= to_pos(d_prod_reg[3]);
            e_seg_reg.nx1 <= d_norm_reg[0];
            e_seg_reg.nz1 <= d_norm_reg[1];
            e_seg_reg.nx2 <= d_norm_reg[2];
            e_seg_reg.nz2 <= d_norm_reg[3];
            e_seg_reg.u1  <= d_tag_reg[0][TAG_W-1:TEX_W];
            e_seg_reg.vt  <= d_tag_reg[0][TEX_W-1:0];
            e_seg_reg.u2  <= d_tag_reg[1][TAG_W-1:TEX_W];
            e_seg_reg.vb  <= d_tag_reg[1][TEX_W-1:0];
        end
    end

    cmg_emit u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (e_vld_reg),
        .in_seg        (e_seg_reg),
        .half          (height_reg[HEIGHT_W-1:1]),
        .take          (en),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_face_number (m_face_number),
        .m_corner      (m_corner),
        .m_pos_x       (m_pos_x),
        .m_pos_y       (m_pos_y),
        .m_pos_z       (m_pos_z),
        .m_norm_x      (m_norm_x),
        .m_norm_y      (m_norm_y),
        .m_norm_z      (m_norm_z),
        .m_tex_u       (m_tex_u),
        .m_tex_v       (m_tex_v),
        .m_last_vertex (m_last_vertex)
    );

endmodule
